// File: hw/rtl/steq_pkg.sv
// ----------------------------------------------------------------------------
// steq_pkg
// Types, codes and helper functions shared by the sorted timer event queue.
// ----------------------------------------------------------------------------
package steq_pkg;

   localparam int DEPTH = 16;

   localparam logic [31:0] EMPTY_DELAY = 32'd100000;
   localparam logic [31:0] RECIP3      = 32'hAAAAAAAB;  // ceil(2^33 / 3)
   localparam logic [31:0] RECIP125    = 32'h83126E98;  // ceil(2^38 / 125)

   typedef enum logic [2:0] {
      OP_ADD     = 3'd0,
      OP_RADD    = 3'd1,
      OP_DELETE  = 3'd2,
      OP_RUN     = 3'd3,
      OP_FIND    = 3'd4,
      OP_SETBACK = 3'd5,
      OP_CLEAR   = 3'd6
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK   = 2'd0,
      STAT_FULL = 2'd1,
      STAT_MISS = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_DELETE,
      CELL_POP,
      CELL_SETBACK,
      CELL_CLEAR
   } cell_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCALE,
      ST_EXEC,
      ST_RUN,
      ST_REPLY
   } state_type;

   typedef struct packed {
      logic [2:0]  op;
      logic [31:0] now;
      logic [15:0] handle;
      logic [23:0] delay;
      logic [7:0]  weight;
      logic [9:0]  rnd;
      logic [31:0] back_by;
   } req_type;

   typedef struct packed {
      logic               kind;
      logic [15:0]        fired_handle;
      logic [1:0]         status;
      logic               found;
      logic signed [31:0] next_delay;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic [31:0] due;
      logic [15:0] handle;
      logic        heavy;
   } data_type;

   typedef struct packed {
      logic     valid;
      data_type data;
   } entry_type;

   typedef struct packed {
      logic after;
      logic seen;
   } link_type;

   typedef struct packed {
      cell_op_type op;
      logic [31:0] due;
      logic [15:0] handle;
      logic        heavy;
      logic [31:0] back;
   } cmd_type;

   function automatic logic [31:0] sat_add(input logic [31:0] now, input logic [24:0] dly);
      logic [32:0] sum;
      sum = {1'b0, now} + 33'(dly);
      return sum[32] ? 32'hFFFFFFFF : sum[31:0];
   endfunction

   function automatic logic [31:0] head_delay(input logic valid, input logic [31:0] due,
                                              input logic [31:0] now);
      logic signed [32:0] diff;
      logic [31:0]        res;
      diff = $signed({1'b0, due}) - $signed({1'b0, now});
      if (!valid) begin
         res = EMPTY_DELAY;
      end else if (diff > 33'sh07FFFFFFF) begin
         res = 32'h7FFFFFFF;
      end else if (diff < -33'sh080000000) begin
         res = 32'h80000000;
      end else begin
         res = diff[31:0];
      end
      return res;
   endfunction

endpackage

// File: hw/rtl/steq_cell.sv
// ----------------------------------------------------------------------------
// steq_cell
// One slot of the sorted entry row: holds an entry and shifts to or from
// its neighbours under the shared command.
// ----------------------------------------------------------------------------
module steq_cell import steq_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  cmd_type   cmd,
   input  entry_type left,
   input  link_type  left_lnk,
   input  entry_type right,
   output entry_type ent,
   output link_type  lnk
);

   logic     valid_ff, valid_in;
   data_type data_ff, data_in;
   logic     match;
   logic     after;
   logic     seen;

   assign match = valid_ff && (data_ff.handle == cmd.handle);
   assign after = valid_ff && (data_ff.due > cmd.due);
   assign seen  = left_lnk.seen | match;

   assign ent = '{valid: valid_ff, data: data_ff};
   assign lnk = '{after: after, seen: seen};

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      case (cmd.op)
         CELL_INSERT: begin
            if (after || (!valid_ff && left.valid)) begin
               valid_in = 1'b1;
               if (left_lnk.after) begin
                  data_in = left.data;
               end else begin
                  data_in = '{due: cmd.due, handle: cmd.handle, heavy: cmd.heavy};
               end
            end
         end
         CELL_DELETE: begin
            if (seen) begin
               valid_in = right.valid;
               data_in  = right.data;
            end
         end
         CELL_POP: begin
            valid_in = right.valid;
            data_in  = right.data;
         end
         CELL_SETBACK: begin
            data_in.due = (data_ff.due > cmd.back) ? data_ff.due - cmd.back : 32'd0;
         end
         CELL_CLEAR: begin
            valid_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

// File: hw/rtl/steq_scale.sv
// ----------------------------------------------------------------------------
// steq_scale
// Four-stage pipeline for the randomised delay:
// t = 2d/3, result = t + rnd*t/1000, small delays pass through.
// ----------------------------------------------------------------------------
module steq_scale import steq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [23:0] delay,
   input  logic [9:0]  rnd,
   output logic        done,
   output logic [24:0] scaled
);

   logic        v1_ff, v2_ff, v3_ff, v4_ff;
   logic [23:0] d1_ff, d2_ff, d3_ff;
   logic        small1_ff, small2_ff, small3_ff;
   logic [9:0]  rnd1_ff;
   logic [23:0] t1_ff, t2_ff, t3_ff;
   logic [33:0] p2_ff;
   logic [23:0] q3_ff;
   logic [24:0] out4_ff;

   logic [56:0] prod1;
   logic [62:0] prod3;

   // divide by three via reciprocal
   assign prod1 = 57'({delay, 1'b0}) * 57'(RECIP3);
   // divide by 1000 as shift by three then reciprocal of 125
   assign prod3 = 63'(p2_ff[33:3]) * 63'(RECIP125);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= start;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      d1_ff     <= delay;
      small1_ff <= (delay < 24'd3);
      rnd1_ff   <= rnd;
      t1_ff     <= prod1[56:33];

      d2_ff     <= d1_ff;
      small2_ff <= small1_ff;
      t2_ff     <= t1_ff;
      p2_ff     <= 34'(rnd1_ff) * 34'(t1_ff);

      d3_ff     <= d2_ff;
      small3_ff <= small2_ff;
      t3_ff     <= t2_ff;
      q3_ff     <= prod3[61:38];

      out4_ff   <= small3_ff ? 25'(d3_ff) : 25'(t3_ff) + 25'(q3_ff);
   end

   assign done   = v4_ff;
   assign scaled = out4_ff;

endmodule

// File: hw/rtl/sorted_timer_event_queue.sv
// ----------------------------------------------------------------------------
// sorted_timer_event_queue
// Up to DEPTH one-shot timers kept in due-time order in a row of cells.
//
// A transaction is taken on req_item when start is high and busy is low.
// Each result appears on rsp_item for one cycle with rsp_strobe high; the
// receiver cannot stall it. The last result of a transaction has last set.
// Add, delete, find, set back and clear work on all cells at once: the
// request passes the execute and reply states, busy drops as the reply
// appears, and a new request can be taken in that same cycle.
// A randomised add first passes the four-stage scaling pipeline, and the
// due-time sum is registered before the add is executed.
// A run pops one due entry per cycle from the head of the row, stopping
// after a heavy entry, each pop giving its fired result in the next cycle;
// a run with nothing due gives a plain reply.
// Reset empties the queue and drops any transaction in progress.
// ----------------------------------------------------------------------------
module sorted_timer_event_queue import steq_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_strobe,
   output rsp_type rsp_item
);

   state_type   state_ff, state_in;
   req_type     req_ff;
   logic [31:0] due_ff, due_in;
   logic [1:0]  status_ff, status_in;
   logic        found_ff, found_in;
   rsp_type     rsp_ff, rsp_in;
   logic        rsp_valid_ff, rsp_valid_in;

   cmd_type     cmd;
   entry_type   ent [DEPTH];
   link_type    lnk [DEPTH];

   logic        accept;
   logic        scale_done;
   logic [24:0] scale_delay;
   logic        full;
   logic        any_match;
   logic        pop;
   logic        more;

   assign accept    = start && !busy;
   assign busy      = (state_ff != ST_IDLE);
   assign full      = ent[DEPTH-1].valid;
   assign any_match = lnk[DEPTH-1].seen;
   assign pop       = ent[0].valid && (ent[0].data.due <= req_ff.now);
   assign more      = !ent[0].data.heavy && ent[1].valid && (ent[1].data.due <= req_ff.now);

   steq_scale u_scale (
      .clock  (clock),
      .reset  (reset),
      .start  (accept && (req_item.op == OP_RADD)),
      .delay  (req_item.delay),
      .rnd    (req_item.rnd),
      .done   (scale_done),
      .scaled (scale_delay)
   );

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      entry_type left_ent;
      link_type  left_lnk;
      entry_type right_ent;

      if (i == 0) begin : g_head
         assign left_ent = '{valid: 1'b1, data: '0};
         assign left_lnk = '{after: 1'b0, seen: 1'b0};
      end else begin : g_mid
         assign left_ent = ent[i-1];
         assign left_lnk = lnk[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign right_ent = '{valid: 1'b0, data: '0};
      end else begin : g_body
         assign right_ent = ent[i+1];
      end

      steq_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cmd      (cmd),
         .left     (left_ent),
         .left_lnk (left_lnk),
         .right    (right_ent),
         .ent      (ent[i]),
         .lnk      (lnk[i])
      );
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_item.op == OP_RADD) begin
                  state_in = ST_SCALE;
               end else if (req_item.op == OP_RUN) begin
                  state_in = ST_RUN;
               end else begin
                  state_in = ST_EXEC;
               end
            end
         end
         ST_SCALE: begin
            if (scale_done) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_REPLY;
         end
         ST_RUN: begin
            if (!pop) begin
               state_in = ST_REPLY;
            end else if (!more) begin
               state_in = ST_IDLE;
            end
         end
         ST_REPLY: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs and datapath control
   always_comb begin
      cmd          = '{op: CELL_HOLD, due: due_ff, handle: req_ff.handle,
                       heavy: |req_ff.weight, back: req_ff.back_by};
      due_in       = due_ff;
      status_in    = status_ff;
      found_in     = found_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               due_in = sat_add(req_item.now, 25'(req_item.delay));
            end
         end
         ST_SCALE: begin
            if (scale_done) begin
               due_in = sat_add(req_ff.now, scale_delay);
            end
         end
         ST_EXEC: begin
            status_in = STAT_OK;
            found_in  = 1'b0;
            case (req_ff.op)
               OP_ADD, OP_RADD: begin
                  if (full) begin
                     status_in = STAT_FULL;
                  end else begin
                     cmd.op = CELL_INSERT;
                  end
               end
               OP_DELETE: begin
                  cmd.op    = CELL_DELETE;
                  status_in = any_match ? STAT_OK : STAT_MISS;
               end
               OP_FIND: begin
                  found_in = any_match;
               end
               OP_SETBACK: begin
                  cmd.op = CELL_SETBACK;
               end
               OP_CLEAR: begin
                  cmd.op = CELL_CLEAR;
               end
               default: begin
               end
            endcase
         end
         ST_RUN: begin
            status_in = STAT_OK;
            found_in  = 1'b0;
            if (pop) begin
               cmd.op       = CELL_POP;
               rsp_valid_in = 1'b1;
               rsp_in       = '{kind: 1'b1, fired_handle: ent[0].data.handle,
                                status: STAT_OK, found: 1'b0,
                                next_delay: head_delay(ent[1].valid, ent[1].data.due,
                                                       req_ff.now),
                                last: !more};
            end
         end
         ST_REPLY: begin
            rsp_valid_in = 1'b1;
            rsp_in       = '{kind: 1'b0, fired_handle: 16'd0, status: status_ff,
                             found: found_ff,
                             next_delay: head_delay(ent[0].valid, ent[0].data.due,
                                                    req_ff.now),
                             last: 1'b1};
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_item;
      end
      due_ff    <= due_in;
      status_ff <= status_in;
      found_ff  <= found_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_item   = rsp_ff;

endmodule

// File: tb/sorted_timer_event_queue_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_timer_event_queue_checker
// Watches the request and result channels of the sorted timer event queue.
// Keeps its own copy of the timer list and works out, for every accepted
// request, the replies and fired events it must cause. It then compares
// each result field by field with the oldest of those still outstanding.
// It hands the number of outstanding results and of mismatches to the top.
// ----------------------------------------------------------------------------
module sorted_timer_event_queue_checker import steq_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_item,
   input  logic    rsp_strobe,
   input  rsp_type rsp_item,
   output int      rsp_outstanding,
   output int      errors
);

   logic [31:0] due_q    [DEPTH];
   logic [15:0] handle_q [DEPTH];
   logic        heavy_q  [DEPTH];
   int          entry_count = 0;

   rsp_type timer_rsp_queue [$];
   int      mismatches = 0;
   int      outstanding = 0;

   assign rsp_outstanding = outstanding;
   assign errors = mismatches;

   task automatic report_error(input string msg);
      if (mismatches < 200) begin
         $display("%0t ns: %s", $time, msg);
      end
      mismatches++;
   endtask

   // head due time relative to now, clipped to the signed 32-bit range; EMPTY_DELAY when empty
   function automatic logic [31:0] due_in(input logic [31:0] now);
      longint diff;
      if (entry_count == 0) begin
         return EMPTY_DELAY;
      end
      diff = longint'({32'd0, due_q[0]}) - longint'({32'd0, now});
      if (diff > 64'sh7FFF_FFFF) begin
         return 32'h7FFF_FFFF;
      end
      if (diff < -64'sh8000_0000) begin
         return 32'h8000_0000;
      end
      return diff[31:0];
   endfunction

   function automatic void remove_entry(input int slot);
      for (int j = slot; j + 1 < entry_count; j++) begin
         due_q[j]    = due_q[j + 1];
         handle_q[j] = handle_q[j + 1];
         heavy_q[j]  = heavy_q[j + 1];
      end
      entry_count--;
   endfunction

   // new entry goes behind every entry due at the same time or earlier
   function automatic status_type insert_entry(input logic [31:0] due,
                                               input logic [15:0] handle,
                                               input logic heavy);
      int slot = 0;
      if (entry_count >= DEPTH) begin
         return STAT_FULL;
      end
      while (slot < entry_count && due_q[slot] <= due) begin
         slot++;
      end
      for (int j = entry_count; j > slot; j--) begin
         due_q[j]    = due_q[j - 1];
         handle_q[j] = handle_q[j - 1];
         heavy_q[j]  = heavy_q[j - 1];
      end
      due_q[slot]    = due;
      handle_q[slot] = handle;
      heavy_q[slot]  = heavy;
      entry_count++;
      return STAT_OK;
   endfunction

   function automatic void queue_rsp(input logic kind, input logic [15:0] handle,
                                     input status_type status, input logic found,
                                     input logic [31:0] next_delay, input logic last);
      rsp_type r;
      r.kind         = kind;
      r.fired_handle = handle;
      r.status       = status;
      r.found        = found;
      r.next_delay   = next_delay;
      r.last         = last;
      timer_rsp_queue.push_back(r);
   endfunction

   function automatic void apply_timer_op(input req_type r);
      status_type  st = STAT_OK;
      logic        fnd = 1'b0;
      logic [63:0] span;
      logic [63:0] third;
      logic [63:0] sum;
      logic [31:0] due;
      logic [15:0] fh;
      logic        hv;
      logic        more;
      int          pops = 0;
      span = 64'(r.delay);
      case (r.op)
         OP_ADD, OP_RADD: begin
            if (r.op == OP_RADD && span >= 3) begin
               third = (2 * span) / 3;
               span  = third + (64'(r.rnd) * third) / 1000;
            end
            sum = 64'(r.now) + span;
            due = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
            st  = insert_entry(due, r.handle, r.weight != 8'd0);
         end
         OP_DELETE: begin
            st = STAT_MISS;
            for (int i = 0; i < entry_count; i++) begin
               if (handle_q[i] == r.handle) begin
                  remove_entry(i);
                  st = STAT_OK;
                  break;
               end
            end
         end
         OP_RUN: begin
            hv = 1'b0;
            // a heavy entry ends the run once it has fired
            while (!hv && entry_count > 0 && due_q[0] <= r.now) begin
               fh = handle_q[0];
               hv = heavy_q[0];
               remove_entry(0);
               more = !hv && entry_count > 0 && due_q[0] <= r.now;
               queue_rsp(1'b1, fh, STAT_OK, 1'b0, due_in(r.now), !more);
               pops++;
            end
            if (pops > 0) begin
               return;
            end
         end
         OP_FIND: begin
            for (int i = 0; i < entry_count; i++) begin
               if (handle_q[i] == r.handle) begin
                  fnd = 1'b1;
               end
            end
         end
         OP_SETBACK: begin
            for (int i = 0; i < entry_count; i++) begin
               due_q[i] = (due_q[i] > r.back_by) ? due_q[i] - r.back_by : 32'd0;
            end
         end
         OP_CLEAR: begin
            entry_count = 0;
         end
         default: begin
         end
      endcase
      queue_rsp(1'b0, 16'd0, st, fnd, due_in(r.now), 1'b1);
   endfunction

   task automatic check_result(input rsp_type got);
      rsp_type want;
      if (timer_rsp_queue.size() == 0) begin
         report_error($sformatf("result with none outstanding: kind %0d handle %0d",
                                got.kind, got.fired_handle));
         return;
      end
      want = timer_rsp_queue.pop_front();
      if (got.kind !== want.kind) begin
         report_error($sformatf("kind: got %0d, want %0d", got.kind, want.kind));
      end
      if (got.fired_handle !== want.fired_handle) begin
         report_error($sformatf("fired_handle: got %0d, want %0d",
                                got.fired_handle, want.fired_handle));
      end
      if (got.status !== want.status) begin
         report_error($sformatf("status: got %0d, want %0d", got.status, want.status));
      end
      if (got.found !== want.found) begin
         report_error($sformatf("found: got %0d, want %0d", got.found, want.found));
      end
      if (got.next_delay !== want.next_delay) begin
         report_error($sformatf("next_delay: got %0d, want %0d",
                                got.next_delay, want.next_delay));
      end
      if (got.last !== want.last) begin
         report_error($sformatf("last: got %0d, want %0d", got.last, want.last));
      end
   endtask

   // results are checked before the transaction taken at the same edge
   always @(posedge clock) begin
      if (reset) begin
         entry_count = 0;
         timer_rsp_queue.delete();
      end else begin
         if (rsp_strobe) begin
            check_result(rsp_item);
         end
         if (start && !busy) begin
            apply_timer_op(req_item);
         end
      end
      outstanding = timer_rsp_queue.size();
   end

endmodule

// File: tb/sorted_timer_event_queue_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_timer_event_queue_test
// Drives the sorted timer event queue with a directed set of requests that
// covers empty and full queues, saturated due times, the randomised add
// corner values, delete misses and runs ending on a heavy entry, then with
// about five hundred random requests around a moving current time. Checking
// is done by the checker instance; this module only drives and decides.
// ----------------------------------------------------------------------------
module sorted_timer_event_queue_test;
   import steq_pkg::*;

   localparam logic [2:0] OP_SPARE = 3'd7;

   logic    clock = 1'b0;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_item;
   logic    rsp_strobe;
   rsp_type rsp_item;
   int      rsp_outstanding;
   int      errors;

   logic        no_idle = 1'b0;
   logic [31:0] cur_now;

   always #1 clock = ~clock;

   sorted_timer_event_queue dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   sorted_timer_event_queue_checker timer_check (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_item        (req_item),
      .rsp_strobe      (rsp_strobe),
      .rsp_item        (rsp_item),
      .rsp_outstanding (rsp_outstanding),
      .errors          (errors)
   );

   function automatic req_type make_req(input logic [2:0] op, input logic [31:0] now,
                                        input logic [15:0] handle, input logic [23:0] delay,
                                        input logic [7:0] weight, input logic [9:0] rnd,
                                        input logic [31:0] back_by);
      req_type r;
      r.op      = op;
      r.now     = now;
      r.handle  = handle;
      r.delay   = delay;
      r.weight  = weight;
      r.rnd     = rnd;
      r.back_by = back_by;
      return r;
   endfunction

   // returns at the edge that takes the transaction, start still high
   task automatic issue(input req_type r);
      int unsigned gap;
      gap = no_idle ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= r;
      do @(posedge clock); while (busy);
   endtask

   task automatic drain();
      start <= 1'b0;
      do @(negedge clock); while (rsp_outstanding != 0);
      @(posedge clock);
   endtask

   initial begin
      #400000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      req_type     r;
      int unsigned pick;
      logic        filling;
      logic [2:0]  op_code;

      reset    <= 1'b1;
      start    <= 1'b0;
      req_item <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // empty queue
      issue(make_req(OP_DELETE, 32'd0, 16'd5, 24'd0, 8'd0, 10'd0, 32'd0));
      issue(make_req(OP_RUN, 32'hFFFF_FFFF, 16'd0, 24'd0, 8'd0, 10'd0, 32'd0));
      issue(make_req(OP_SPARE, 32'd0, 16'd0, 24'd0, 8'd0, 10'd0, 32'd0));
      // saturated due time, then both ends of the head delay clip
      issue(make_req(OP_ADD, 32'hFFFF_FFFF, 16'hFFFF, 24'hFF_FFFF, 8'hFF, 10'h3FF, 32'd0));
      issue(make_req(OP_FIND, 32'd0, 16'hFFFF, 24'd0, 8'd0, 10'd0, 32'd0));
      issue(make_req(OP_ADD, 32'd0, 16'd0, 24'd0, 8'd0, 10'd0, 32'd0));
      issue(make_req(OP_FIND, 32'hFFFF_FFFF, 16'd1234, 24'd0, 8'd0, 10'd0, 32'd0));
      // randomised add corners
      issue(make_req(OP_RADD, 32'd1000, 16'd1, 24'd2, 8'd0, 10'd500, 32'd0));
      issue(make_req(OP_RADD, 32'd1000, 16'd2, 24'd3, 8'd0, 10'd0, 32'd0));
      issue(make_req(OP_RADD, 32'd0, 16'd3, 24'hFF_FFFF, 8'd1, 10'd1023, 32'd0));
      issue(make_req(OP_RADD, 32'd5000, 16'd4, 24'd300, 8'd0, 10'd999, 32'd0));
      // fill up with equal due times in pairs, last one dropped
      for (int k = 0; k < 11; k++) begin
         issue(make_req(OP_ADD, 32'd100, 16'(16 + k), 24'((k / 2) * 10),
                        (k % 4 == 3) ? 8'h80 : 8'd0, 10'd0, 32'd0));
      end
      issue(make_req(OP_DELETE, 32'd0, 16'd2, 24'd0, 8'd0, 10'd0, 32'd0));
      issue(make_req(OP_RUN, 32'd2000, 16'd0, 24'd0, 8'd0, 10'd0, 32'd0));
      issue(make_req(OP_SETBACK, 32'd0, 16'd0, 24'd0, 8'd0, 10'd0, 32'hFFFF_FFFF));
      issue(make_req(OP_RUN, 32'd0, 16'd0, 24'd0, 8'd0, 10'd0, 32'd0));
      issue(make_req(OP_CLEAR, 32'd0, 16'd0, 24'd0, 8'd0, 10'd0, 32'd0));
      drain();

      cur_now = $urandom_range(0, 1000000);
      for (int n = 0; n < 500; n++) begin
         no_idle = ((n / 40) % 4 == 1);
         filling = ((n / 100) % 2 == 0);
         pick    = $urandom_range(0, 99);
         if (pick < (filling ? 40 : 25)) begin
            op_code = OP_ADD;
         end else if (pick < (filling ? 60 : 35)) begin
            op_code = OP_RADD;
         end else if (pick < (filling ? 70 : 55)) begin
            op_code = OP_DELETE;
         end else if (pick < 80) begin
            op_code = OP_RUN;
         end else if (pick < 90) begin
            op_code = OP_FIND;
         end else if (pick < 95) begin
            op_code = OP_SETBACK;
         end else if (pick < 98) begin
            op_code = OP_CLEAR;
         end else begin
            op_code = OP_SPARE;
         end
         cur_now = cur_now + $urandom_range(0, 12);
         if ($urandom_range(0, 49) == 0) begin
            cur_now = $urandom();
         end
         r.op      = op_code;
         r.now     = ($urandom_range(0, 9) == 0) ? $urandom() : cur_now;
         r.handle  = ($urandom_range(0, 9) == 0) ? 16'($urandom())
                                                  : 16'($urandom_range(0, 23));
         r.delay   = ($urandom_range(0, 9) == 0) ? 24'($urandom())
                                                  : 24'($urandom_range(0, 60));
         r.weight  = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255)) : 8'd0;
         r.rnd     = 10'($urandom_range(0, 1023));
         r.back_by = ($urandom_range(0, 4) == 0) ? $urandom() : $urandom_range(0, 40);
         issue(r);
         if (n % 125 == 124) begin
            drain();
         end
      end
      drain();
      repeat (30) @(posedge clock);

      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
